// ===== hdl/lms_pkg.sv =====
// Shared types, constants and helper functions for the LED matrix scroll scanner.
`default_nettype none
package lms_pkg;

    localparam int ROWS_DEF     = 8;
    localparam int ROW_BITS_DEF = 16;
    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_BITS   = 8;
    localparam int CFG_W        = 4;
    localparam int POS_W        = 5;
    localparam int PHASE_W      = 3;
    localparam int FRAME_W      = 3;
    localparam int OUT_DATA_W   = 32;
    localparam int IN_DATA_W    = GLYPH_ROWS * GLYPH_BITS;

    typedef enum logic [0:0]
    {
        CFG_SHIFT_STEP      = 1'b0,
        CFG_FRAMES_PER_STEP = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0]
    {
        SCAN_IDLE = 1'b0,
        SCAN_RUN  = 1'b1
    } scan_state_t;

    // Update command broadcast to every row lane.
    typedef struct packed
    {
        logic               update;
        logic [CFG_W-1:0]   shift;
        logic [POS_W-1:0]   pos;
    } lane_ctrl_t;

    // Start command for the scan sequencer.
    typedef struct packed
    {
        logic               start;
        logic [FRAME_W-1:0] frames_m1;
        logic               char_end;
    } scan_start_t;

    // Register values outside 1..8 behave as the nearest legal value.
    function automatic logic [CFG_W-1:0] clamp_1_8(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > CFG_W'(8))
            r = CFG_W'(8);
        else
            r = v;
        return r;
    endfunction

    // Steps per character: eight columns divided by the step width.
    function automatic logic [CFG_W-1:0] steps_per_char(input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] r;
        unique case (s)
            CFG_W'(1):                         r = CFG_W'(8);
            CFG_W'(2):                         r = CFG_W'(4);
            CFG_W'(3), CFG_W'(4):              r = CFG_W'(2);
            default:                           r = CFG_W'(1);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/led_matrix_scroll_scanner.sv =====
// Each accepted beat is one scroll step: the eight glyph rows of the current character are merged
// into the row stores (one lane per row, all updated in the cycle after the beat), and the block
// then emits frames_per_step scans of ROWS row frames, one frame per cycle while the output is
// taken, through the single output register that the scan sequencer feeds; the next step is
// accepted once the last frame of the current one has been loaded into that register.
// Configuration writes take effect on the next step and should only be made while the block
// is idle.
`default_nettype none
module led_matrix_scroll_scanner #(
    parameter int ROWS     = lms_pkg::ROWS_DEF,
    parameter int ROW_BITS = lms_pkg::ROW_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [lms_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [lms_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // glyph_rows[63:0]
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [lms_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // row_data[15:0], row_select_n[23:16], char_end[24]
    output logic                                m_axis_tlast
);
    import lms_pkg::*;

    logic [CFG_W-1:0]    shift_step_reg, shift_step_next;
    logic [CFG_W-1:0]    frames_reg, frames_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;

    logic                accept;
    logic                busy;
    logic [CFG_W-1:0]    s_eff;
    logic [CFG_W-1:0]    f_eff;
    logic [CFG_W-1:0]    count;
    logic [PHASE_W-1:0]  phase_eff;
    logic [6:0]          offset;
    logic [CFG_W-1:0]    phase_inc;
    logic                char_end;
    lane_ctrl_t          lane_ctrl;
    scan_start_t         scan_cmd;
    logic [ROW_BITS-1:0] row_words [ROWS];

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && !busy;

    always_comb
    begin
        shift_step_next = shift_step_reg;
        frames_next     = frames_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SHIFT_STEP:      shift_step_next = cfg_wdata;
                CFG_FRAMES_PER_STEP: frames_next     = cfg_wdata;
                default:             shift_step_next = shift_step_reg;
            endcase
        end
    end

    // A phase left over from a narrower step setting restarts the character.
    always_comb
    begin
        s_eff     = clamp_1_8(shift_step_reg);
        f_eff     = clamp_1_8(frames_reg);
        count     = steps_per_char(s_eff);
        phase_eff = ({1'b0, phase_reg} >= count) ? '0 : phase_reg;
        offset    = phase_eff * s_eff;
        phase_inc = {1'b0, phase_eff} + CFG_W'(1);
        char_end  = (phase_inc >= count);
        phase_next = phase_reg;
        if (accept)
            phase_next = char_end ? '0 : phase_inc[PHASE_W-1:0];

        lane_ctrl.update = accept;
        lane_ctrl.shift  = s_eff;
        lane_ctrl.pos    = POS_W'(ROW_BITS - 1) - {2'b0, offset[2:0]};

        scan_cmd.start     = accept;
        scan_cmd.frames_m1 = FRAME_W'(f_eff - CFG_W'(1));
        scan_cmd.char_end  = char_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_step_reg <= CFG_W'(1);
            frames_reg     <= CFG_W'(1);
            phase_reg      <= '0;
        end
        else
        begin
            shift_step_reg <= shift_step_next;
            frames_reg     <= frames_next;
            phase_reg      <= phase_next;
        end
    end

    generate
        for (genvar r = 0; r < ROWS; r++)
        begin : g_lane
            logic [GLYPH_BITS-1:0] glyph;
            if (r < GLYPH_ROWS)
            begin : g_glyph
                assign glyph = s_axis_tdata[GLYPH_BITS*r +: GLYPH_BITS];
            end
            else
            begin : g_blank
                assign glyph = '0;
            end

            lms_lane #(
                .ROW_BITS (ROW_BITS)
            ) u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (lane_ctrl),
                .glyph    (glyph),
                .row_word (row_words[r])
            );
        end
    endgenerate

    lms_scan #(
        .ROWS     (ROWS),
        .ROW_BITS (ROW_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (scan_cmd),
        .rows          (row_words),
        .busy          (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== hdl/lms_lane.sv =====
// One row lane: holds a row word and applies the scroll shift and glyph merge.
`default_nettype none
module lms_lane #(
    parameter int ROW_BITS = lms_pkg::ROW_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lms_pkg::lane_ctrl_t          ctrl,
    input  wire logic [lms_pkg::GLYPH_BITS-1:0] glyph,
    output logic [ROW_BITS-1:0]               row_word
);
    import lms_pkg::*;

    logic [ROW_BITS-1:0]            row_reg;
    logic [ROW_BITS-1:0]            row_next;
    logic [ROW_BITS+GLYPH_BITS-1:0] placed;

    always_comb
    begin
        placed   = {{ROW_BITS{1'b0}}, glyph} << ctrl.pos;
        row_next = row_reg;
        if (ctrl.update)
            row_next = (row_reg >> ctrl.shift) | placed[ROW_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else
            row_reg <= row_next;
    end

    assign row_word = row_reg;

endmodule
`default_nettype wire

// ===== hdl/lms_scan.sv =====
// Scan sequencer: merges the row lanes into a stream of row frames.
`default_nettype none
module lms_scan #(
    parameter int ROWS     = lms_pkg::ROWS_DEF,
    parameter int ROW_BITS = lms_pkg::ROW_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lms_pkg::scan_start_t            cmd,
    input  wire logic [ROW_BITS-1:0]             rows [ROWS],
    output logic                                 busy,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import lms_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    scan_state_t            state_reg, state_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;
    logic [FRAME_W-1:0]     frames_m1_reg, frames_m1_next;
    logic                   char_end_reg, char_end_next;
    logic                   valid_reg, valid_next;
    logic [OUT_DATA_W-1:0]  data_reg, data_next;
    logic                   last_reg, last_next;

    logic                   load;
    logic                   row_last;
    logic                   frame_last;
    logic [ROW_BITS-1:0]    cur_row;
    logic [15:0]            row_data;
    logic [7:0]             row_select_n;

    assign cur_row = rows[row_reg];

    generate
        if (ROW_BITS >= 16)
        begin : g_wide
            assign row_data = cur_row[15:0];
        end
        else
        begin : g_narrow
            assign row_data = {{(16-ROW_BITS){1'b0}}, cur_row};
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            row_select_n[i] = !(int'(row_reg) == i);
    end

    assign row_last   = (row_reg == RW'(ROWS - 1));
    assign frame_last = (frame_reg == frames_m1_reg);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        frame_next     = frame_reg;
        frames_m1_next = frames_m1_reg;
        char_end_next  = char_end_reg;
        valid_next     = valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        load           = 1'b0;

        if (valid_reg && m_axis_tready)
            valid_next = 1'b0;

        unique case (state_reg)
            SCAN_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next     = SCAN_RUN;
                    row_next       = '0;
                    frame_next     = '0;
                    frames_m1_next = cmd.frames_m1;
                    char_end_next  = cmd.char_end;
                end
            end
            SCAN_RUN:
            begin
                load = !valid_reg || m_axis_tready;
                if (load)
                begin
                    valid_next = 1'b1;
                    data_next  = {7'b0, char_end_reg, row_select_n, row_data};
                    last_next  = row_last && frame_last;
                    if (row_last)
                    begin
                        row_next   = '0;
                        frame_next = frame_reg + FRAME_W'(1);
                        if (frame_last)
                            state_next = SCAN_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SCAN_IDLE;
            row_reg       <= '0;
            frame_reg     <= '0;
            frames_m1_reg <= '0;
            char_end_reg  <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            frame_reg     <= frame_next;
            frames_m1_reg <= frames_m1_next;
            char_end_reg  <= char_end_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign busy          = (state_reg == SCAN_RUN);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the scrolling LED matrix row-scan driver.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lms_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_SETTLE   = 4;
    localparam int FINAL_SETTLE   = 20;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [15:0] row_data;
        logic [7:0]  row_select_n;
        logic        char_end;
        logic        last;
    } row_frame_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = CFG_SHIFT_STEP;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Testbench copy of the block state and registers.
    logic [15:0]      lane_rows [8] = '{default: '0};
    logic [2:0]       char_phase = '0;
    logic [CFG_W-1:0] step_width_reg = 4'd1;
    logic [CFG_W-1:0] scan_count_reg = 4'd1;

    row_frame_t frames_due[$];
    int error_count   = 0;
    int steps_taken   = 0;
    int frames_seen   = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    led_matrix_scroll_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // glyph_rows[63:0]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // row_data[15:0], row_select_n[23:16], char_end[24]
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Register values outside 1..8 act as the nearest legal value.
    function automatic int clamp_reg(input logic [CFG_W-1:0] v);
        int r;
        r = int'(v);
        if (r == 0)
            r = 1;
        else if (r > 8)
            r = 8;
        return r;
    endfunction

    // Applies one scroll step to the row copies and queues the row frames it yields.
    function automatic void advance_scroll(input logic [IN_DATA_W-1:0] glyphs);
        int         s;
        int         scans;
        int         steps;
        int         ph;
        int         pos;
        logic       ends_char;
        logic [31:0] placed;
        row_frame_t fr;
        s     = clamp_reg(step_width_reg);
        scans = clamp_reg(scan_count_reg);
        steps = 8 / s;
        ph    = int'(char_phase);
        // A phase left over from a larger step count restarts the character.
        if (ph >= steps)
            ph = 0;
        pos = 15 - ph * s;
        for (int r = 0; r < 8; r++)
        begin
            placed = 32'(glyphs[8*r +: 8]) << pos;
            lane_rows[r] = (lane_rows[r] >> s) | placed[15:0];
        end
        ph = ph + 1;
        ends_char = (ph >= steps);
        char_phase = ends_char ? 3'd0 : 3'(ph);
        for (int f = 0; f < scans; f++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                fr.row_data     = lane_rows[r];
                fr.row_select_n = ~(8'd1 << r);
                fr.char_end     = ends_char;
                fr.last         = (f == scans - 1) && (r == 7);
                frames_due.push_back(fr);
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Input beats, register writes and output beats are all handled at the same edge
    // so the expected frames are always queued before they can be compared.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SHIFT_STEP)
                    step_width_reg = cfg_wdata;
                else
                    scan_count_reg = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_scroll(s_axis_tdata);
                steps_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                frames_seen++;
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected row frame, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    row_frame_t want;
                    want = frames_due.pop_front();
                    compare_field("row_data", 32'(want.row_data), 32'(m_axis_tdata[15:0]));
                    compare_field("row_select_n", 32'(want.row_select_n),
                                  32'(m_axis_tdata[23:16]));
                    compare_field("char_end", 32'(want.char_end), 32'(m_axis_tdata[24]));
                    compare_field("tdata padding", '0, 32'(m_axis_tdata[31:25]));
                    compare_field("tlast", 32'(want.last), 32'(m_axis_tlast));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d frames outstanding",
                     $time, idle_cycles, frames_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // Output side: random stalls, plus long holds requested by the tests.
    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_served != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
            m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic send_step(input logic [IN_DATA_W-1:0] glyphs);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = glyphs;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] shift, input logic [CFG_W-1:0] scans);
        drain();
        write_reg(CFG_SHIFT_STEP, shift);
        write_reg(CFG_FRAMES_PER_STEP, scans);
    endtask

    function automatic logic [IN_DATA_W-1:0] random_glyphs();
        logic [IN_DATA_W-1:0] g;
        case ($urandom_range(0, 7))
            0:       g = '0;
            1:       g = '1;
            2:       g = 64'd1 << $urandom_range(0, 63);
            default: g = {$urandom, $urandom};
        endcase
        return g;
    endfunction

    // Reset values of both registers, with full, empty and alternating glyphs.
    task automatic test_default_scroll();
        send_step(64'hFFFF_FFFF_FFFF_FFFF);
        send_step(64'h0);
        send_step(64'hAAAA_AAAA_AAAA_AAAA);
        send_step(64'h5555_5555_5555_5555);
        send_step(64'h8040_2010_0804_0201);
    endtask

    // Zero acts as one and values above eight as eight, for both registers.
    task automatic test_register_saturation();
        configure(4'd0, 4'd0);
        send_step(64'hF0F0_F0F0_F0F0_F0F0);
        send_step(64'h0F0F_0F0F_0F0F_0F0F);
        configure(4'd15, 4'd15);
        send_step(64'hFFFF_FFFF_FFFF_FFFF);
        send_step(64'h0123_4567_89AB_CDEF);
        configure(4'd9, 4'd9);
        send_step(64'hFEDC_BA98_7654_3210);
    endtask

    // A step of three columns ends the character after two steps.
    task automatic test_odd_step_wrap();
        configure(4'd3, 4'd2);
        send_step(64'hFFFF_FFFF_FFFF_FFFF);
        send_step(64'h8181_8181_8181_8181);
        send_step(64'h7E7E_7E7E_7E7E_7E7E);
    endtask

    // Five steps at width one leave the phase beyond what width two allows.
    task automatic test_phase_past_count();
        configure(4'd8, 4'd1);
        send_step(64'h0);
        configure(4'd1, 4'd1);
        repeat (5) send_step(64'hC3C3_C3C3_C3C3_C3C3);
        configure(4'd2, 4'd1);
        send_step(64'hFFFF_FFFF_FFFF_FFFF);
        send_step(64'h1111_2222_4444_8888);
    endtask

    // Mostly whole characters with one glyph held over all their steps, some noise steps.
    task automatic test_random_traffic(input int send_idle, input int sink_stall,
                                       input int n_steps);
        int                   sent;
        int                   char_steps;
        logic [CFG_W-1:0]     shift;
        logic [CFG_W-1:0]     scans;
        logic [IN_DATA_W-1:0] glyphs;
        sent = 0;
        send_idle_pct  = send_idle;
        sink_stall_pct = sink_stall;
        while (sent < n_steps)
        begin
            if (sent % 12 == 0)
            begin
                shift = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 15))
                                                    : CFG_W'($urandom_range(1, 8));
                scans = ($urandom_range(0, 9) < 8) ? CFG_W'($urandom_range(0, 2))
                                                   : CFG_W'($urandom_range(3, 15));
                configure(shift, scans);
            end
            glyphs = random_glyphs();
            char_steps = ($urandom_range(0, 3) == 0) ? 1 : 8 / clamp_reg(shift);
            for (int k = 0; k < char_steps && sent < n_steps; k++)
            begin
                send_step(glyphs);
                sent++;
            end
        end
    endtask

    // The output is held off for a long stretch while steps keep coming.
    task automatic test_output_backpressure();
        configure(4'd1, 4'd2);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_requests++;
        repeat (10) send_step(random_glyphs());
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_scroll();
        test_register_saturation();
        test_odd_step_wrap();
        test_phase_past_count();
        test_random_traffic(0, 0, 35);
        test_random_traffic(77, 0, 35);
        test_random_traffic(0, 77, 35);
        test_random_traffic(37, 37, 35);
        test_output_backpressure();

        drain();
        repeat (FINAL_SETTLE) @(posedge clk);
        $display("Ran %0d scroll steps and checked %0d row frames, %0d errors.",
                 steps_taken, frames_seen, error_count);
        $display("Covered clamped registers, phase restart, idle and stall mixes, a long hold.");
        if (error_count == 0 && frames_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
